FILE: rtl/tsrl_pkg.sv
// ----------------------------------------------------------------------------
// tsrl_pkg
// shared types and constants for the time-sorted ring log
// ----------------------------------------------------------------------------
`default_nettype none

package tsrl_pkg;

  localparam int unsigned LOG_DEPTH = 64;

  localparam logic [2:0] ST_MERGED   = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_APPENDED = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_BATCH    = 3'd4;

  localparam logic OP_BATCH = 1'b0;
  localparam logic KIND_MOVE = 1'b0;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] id;
    logic [1:0]  kmask;
    logic [63:0] move;
    logic [63:0] dxy;
    logic [31:0] dz;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/tsrl_mem.sv
// ----------------------------------------------------------------------------
// tsrl_mem
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tsrl_mem #(
  parameter int unsigned DEPTH = tsrl_pkg::LOG_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire tsrl_pkg::entry_t  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output tsrl_pkg::entry_t       rd_data_o
);

  tsrl_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/time_sorted_ring_log_insert.sv
// A batch start or a push into an empty log needs no scan; a merge, append
// or drop scans the stored entries, and a middle insert scans them and then
// shifts the entries up to the insert position. Every step is bound by the
// single read port of the entry store, which the scan and the shift visit
// one entry a cycle. The result waits in an output register; s_axis_tready
// is high only between requests.
// ----------------------------------------------------------------------------
// time_sorted_ring_log_insert
// timestamp-ordered ring log with merge, append, insert and eviction
// ----------------------------------------------------------------------------
`default_nettype none

module time_sorted_ring_log_insert #(
  parameter int unsigned LOG_DEPTH = tsrl_pkg::LOG_DEPTH,
  localparam int unsigned AW = $clog2(LOG_DEPTH),
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1),
  localparam int unsigned OW = AW + CW + 1 + AW + 32,
  localparam int unsigned OWB = ((OW + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // obj_id, stamp, val_a, val_b, val_c
  input  wire logic [159:0]     s_axis_tdata_i,
  // op, kind
  input  wire logic [1:0]       s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // slot, count, earliest_valid, mark_slot, earliest_stamp, zero fill
  output logic [OWB-1:0]        m_axis_tdata_o,
  // status
  output logic [2:0]            m_axis_tuser_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_WRD, S_WRW, S_DONE
  } state_e;

  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(LOG_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);
  localparam logic [AW-1:0] LAST_S  = AW'(LOG_DEPTH - 1);

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic ev_q, ev_d;
  logic [AW-1:0] es_slot_q, es_slot_d;
  logic [31:0] es_stamp_q, es_stamp_d;
  logic [31:0] id_q, id_d, ts_q, ts_d, va_q, va_d, vb_q, vb_d, vc_q, vc_d;
  logic kind_q, kind_d;
  logic [CW-1:0] rd_pos_q, rd_pos_d;
  logic chk_vld_q, chk_vld_d;
  logic [AW-1:0] chk_pos_q, chk_pos_d;
  logic ins_found_q, ins_found_d;
  logic [AW-1:0] ins_pos_q, ins_pos_d;
  logic [2:0] st_q, st_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] sh_pos_q, sh_pos_d;
  logic [AW-1:0] sh_end_q, sh_end_d;
  logic cp_vld_q, cp_vld_d;
  logic [AW-1:0] cp_src_q, cp_src_d;
  logic grow_q, grow_d;
  logic out_vld_q, out_vld_d;
  logic [OWB-1:0] out_data_q, out_data_d;
  logic [2:0] out_user_q, out_user_d;

  logic mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  tsrl_pkg::entry_t mem_wr_data, mem_rd_data;

  logic full;
  logic [AW-1:0] chk_phys, p_sel;
  logic [1:0] kbit;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] prev_s(input logic [AW-1:0] s);
    return (s == '0) ? LAST_S : s - AW'(1);
  endfunction

  function automatic logic [AW-1:0] next_s(input logic [AW-1:0] s);
    return (s == LAST_S) ? '0 : s + AW'(1);
  endfunction

  tsrl_mem #(
    .DEPTH (LOG_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  assign full = (count_q >= DEPTH_C);
  assign chk_phys = phys(head_q, chk_pos_q);
  assign kbit = (kind_q == tsrl_pkg::KIND_MOVE) ? 2'b01 : 2'b10;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o = out_data_q;
  assign m_axis_tuser_o = out_user_q;

  always_comb begin
    state_d = state_q;
    head_d = head_q;
    count_d = count_q;
    ev_d = ev_q;
    es_slot_d = es_slot_q;
    es_stamp_d = es_stamp_q;
    id_d = id_q;
    ts_d = ts_q;
    va_d = va_q;
    vb_d = vb_q;
    vc_d = vc_q;
    kind_d = kind_q;
    rd_pos_d = rd_pos_q;
    chk_vld_d = 1'b0;
    chk_pos_d = chk_pos_q;
    ins_found_d = ins_found_q;
    ins_pos_d = ins_pos_q;
    st_d = st_q;
    slot_d = slot_q;
    sh_pos_d = sh_pos_q;
    sh_end_d = sh_end_q;
    cp_vld_d = 1'b0;
    cp_src_d = cp_src_q;
    grow_d = grow_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    mem_wr_en = 1'b0;
    mem_wr_addr = slot_q;
    mem_wr_data = mem_rd_data;
    mem_rd_en = 1'b0;
    mem_rd_addr = slot_q;
    p_sel = ins_pos_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          id_d = s_axis_tdata_i[31:0];
          ts_d = s_axis_tdata_i[63:32];
          va_d = s_axis_tdata_i[95:64];
          vb_d = s_axis_tdata_i[127:96];
          vc_d = s_axis_tdata_i[159:128];
          kind_d = s_axis_tuser_i[1];
          rd_pos_d = '0;
          ins_found_d = 1'b0;
          if (s_axis_tuser_i[0] == tsrl_pkg::OP_BATCH) begin
            ev_d = 1'b0;
            es_slot_d = '0;
            es_stamp_d = '0;
            st_d = tsrl_pkg::ST_BATCH;
            slot_d = '0;
            state_d = S_DONE;
          end else if (count_q == '0) begin
            slot_d = head_q;
            count_d = CW'(1);
            st_d = tsrl_pkg::ST_APPENDED;
            state_d = S_WRD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read one entry per cycle, check it in the cycle after
        if (rd_pos_q < count_q) begin
          mem_rd_en = 1'b1;
          mem_rd_addr = phys(head_q, rd_pos_q[AW-1:0]);
          rd_pos_d = rd_pos_q + CW'(1);
          chk_vld_d = 1'b1;
          chk_pos_d = rd_pos_q[AW-1:0];
        end
        if (chk_vld_q) begin
          if (mem_rd_data.stamp == ts_q && mem_rd_data.id == id_q) begin
            slot_d = chk_phys;
            st_d = tsrl_pkg::ST_MERGED;
            chk_vld_d = 1'b0;
            state_d = S_WRD;
          end else begin
            if (mem_rd_data.stamp <= ts_q) begin
              ins_found_d = 1'b1;
              ins_pos_d = chk_pos_q;
              p_sel = chk_pos_q;
            end
            if ((CW + 1)'(chk_pos_q) == {1'b0, count_q} - (CW + 1)'(1)) begin
              chk_vld_d = 1'b0;
              if (ts_q > mem_rd_data.stamp) begin
                slot_d = next_s(chk_phys);
                st_d = tsrl_pkg::ST_APPENDED;
                if (full) begin
                  head_d = next_s(head_q);
                end else begin
                  count_d = count_q + CW'(1);
                end
                state_d = S_WRD;
              end else if (ins_found_d) begin
                slot_d = phys(head_q, p_sel);
                st_d = tsrl_pkg::ST_INSERTED;
                sh_pos_d = full ? CW'(1) : '0;
                sh_end_d = p_sel;
                grow_d = !full;
                state_d = S_SHIFT;
              end else begin
                st_d = tsrl_pkg::ST_DROPPED;
                slot_d = '0;
                state_d = S_DONE;
              end
            end
          end
        end
      end
      S_SHIFT: begin
        // move each older entry one slot toward the head
        if (sh_pos_q <= CW'(sh_end_q)) begin
          mem_rd_en = 1'b1;
          mem_rd_addr = phys(head_q, sh_pos_q[AW-1:0]);
          cp_vld_d = 1'b1;
          cp_src_d = mem_rd_addr;
          sh_pos_d = sh_pos_q + CW'(1);
        end
        if (cp_vld_q) begin
          mem_wr_en = 1'b1;
          mem_wr_addr = prev_s(cp_src_q);
          mem_wr_data = mem_rd_data;
        end else if (sh_pos_q > CW'(sh_end_q)) begin
          if (grow_q) begin
            count_d = count_q + CW'(1);
            head_d = prev_s(head_q);
          end
          state_d = S_WRD;
        end
      end
      S_WRD: begin
        mem_rd_en = 1'b1;
        mem_rd_addr = slot_q;
        state_d = S_WRW;
      end
      S_WRW: begin
        mem_wr_en = 1'b1;
        mem_wr_addr = slot_q;
        mem_wr_data = mem_rd_data;
        mem_wr_data.stamp = ts_q;
        mem_wr_data.id = id_q;
        mem_wr_data.kmask = (st_q == tsrl_pkg::ST_MERGED) ?
                            (mem_rd_data.kmask | kbit) : kbit;
        if (kind_q == tsrl_pkg::KIND_MOVE) begin
          mem_wr_data.move = {vb_q, va_q};
        end else begin
          mem_wr_data.dxy = {vb_q, va_q};
          mem_wr_data.dz = vc_q;
        end
        if (!ev_q || ts_q < es_stamp_q) begin
          ev_d = 1'b1;
          es_slot_d = slot_q;
          es_stamp_d = ts_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_user_d = st_q;
          out_data_d = OWB'({es_stamp_q, es_slot_q, ev_q, count_q, slot_q});
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= '0;
      count_q <= '0;
      ev_q <= 1'b0;
      es_slot_q <= '0;
      es_stamp_q <= '0;
      chk_vld_q <= 1'b0;
      cp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      count_q <= count_d;
      ev_q <= ev_d;
      es_slot_q <= es_slot_d;
      es_stamp_q <= es_stamp_d;
      chk_vld_q <= chk_vld_d;
      cp_vld_q <= cp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    ts_q <= ts_d;
    va_q <= va_d;
    vb_q <= vb_d;
    vc_q <= vc_d;
    kind_q <= kind_d;
    rd_pos_q <= rd_pos_d;
    chk_pos_q <= chk_pos_d;
    ins_found_q <= ins_found_d;
    ins_pos_q <= ins_pos_d;
    st_q <= st_d;
    slot_q <= slot_d;
    sh_pos_q <= sh_pos_d;
    sh_end_q <= sh_end_d;
    cp_src_q <= cp_src_d;
    grow_q <= grow_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count above log depth");

  a_mark_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ev_q |-> (es_slot_q == '0 && es_stamp_q == '0))
    else $error("earliest mark not cleared");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRW |=> state_q == S_DONE && ev_q)
    else $error("entry write did not set the earliest mark");

  a_batch_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) && out_user_q == tsrl_pkg::ST_BATCH |-> !out_data_q[AW + CW])
    else $error("batch start reported a valid mark");

endmodule

`default_nettype wire
